// ===== hw/rtl/lldq_pkg.sv =====
// Shared types and constants for the linked list deque.
package lldq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned SlotW = 7;
  localparam logic [SlotW-1:0] NullSlot = 7'd64;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpDelKey = 3'd1;
  localparam logic [2:0] OpDelFirst = 3'd2;
  localparam logic [2:0] OpDelLast = 3'd3;
  localparam logic [2:0] OpDump = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  entries;
    logic        last_of_run;
  } rsp_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CmdNone, CmdLatch, CmdRdFree, CmdInsert, CmdFixHead, CmdRdNode, CmdUnlinkA,
    CmdUnlinkB, CmdUnlinkC, CmdStep, CmdEmit
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  status;
    logic        use_value;
    logic        last;
    logic        sel_tail;
  } ctl_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       empty;
    logic       full;
    logic       cur_null;
    logic       match;
    logic       walk_done;
  } sts_t;

endpackage

// ===== hw/rtl/linked_list_deque_with_key_delete.sv =====
// Top level of the bounded doubly linked list deque with delete by key.
// Busy covers the whole transaction: a full insert, an empty delete or dump and unused
// opcodes end without reading a slot, delete by key visits entries until a match, which it
// unlinks, or the end of the list, and dump gives one result per entry; each visit waits on the registered slot read.
// The last result comes in the final busy cycle; a new transaction is accepted once busy falls.
// Results cannot be stalled by the receiver; reset empties the list at once.
module linked_list_deque_with_key_delete (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lldq_pkg::req_t req_i,
  output lldq_pkg::rsp_t rsp_o,
  output logic           rsp_valid_o
);

  lldq_pkg::ctl_t ctl;
  lldq_pkg::sts_t sts;
  lldq_pkg::rsp_t dp_rsp;
  logic           dp_valid;
  logic           ctl_busy;
  logic           done;
  logic [lldq_pkg::SlotW-1:0] cnt;
  logic           fix_q;

  lldq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .opcode_i(req_i.opcode),
    .sts_i(sts), .ctl_o(ctl), .busy_o(ctl_busy)
  );

  lldq_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .ctl_i(ctl), .sts_o(sts),
    .rsp_o(dp_rsp), .rsp_valid_o(dp_valid), .cnt_o(cnt)
  );

  // Insert and delete finish in the fix cycle without an emit command.
  assign done = fix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_q <= 1'b0;
    end else begin
      fix_q <= (ctl.cmd == lldq_pkg::CmdUnlinkC) || (ctl.cmd == lldq_pkg::CmdInsert);
    end
  end

  lldq_emit u_emit (
    .clk_i, .rst_ni, .done_i(done), .dp_valid_i(dp_valid), .dp_rsp_i(dp_rsp),
    .entries_i(cnt), .rsp_o(rsp_o), .valid_o(rsp_valid_o)
  );

  assign busy = ctl_busy;

  property p_busy_after_accept;
    @(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy;
  endproperty
  a_busy_hold: assert property (p_busy_after_accept) else $error("busy not raised");

  a_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.last_of_run) |=> !busy || ctl.cmd == lldq_pkg::CmdNone)
    else $error("work after last result");

  a_entries_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.entries <= 7'd64) else $error("entries overflow");

endmodule

// ===== hw/rtl/lldq_datapath.sv =====
// Datapath of the linked list deque: slot memories, pointers and result register.
module lldq_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lldq_pkg::req_t req_i,
  input  lldq_pkg::ctl_t ctl_i,
  output lldq_pkg::sts_t sts_o,
  output lldq_pkg::rsp_t rsp_o,
  output logic           rsp_valid_o,
  output logic [lldq_pkg::SlotW-1:0] cnt_o
);

  localparam int unsigned AW = lldq_pkg::SlotW - 1;

  logic [31:0] key_mem [lldq_pkg::Capacity];
  logic [lldq_pkg::SlotW-1:0] nxt_mem [lldq_pkg::Capacity];
  logic [lldq_pkg::SlotW-1:0] prv_mem [lldq_pkg::Capacity];

  logic [2:0]  op_q;
  logic [31:0] key_q;
  logic [lldq_pkg::SlotW-1:0] head_q, tail_q, free_q, fresh_q, cnt_q, cur_q, idx_q;
  logic [lldq_pkg::SlotW-1:0] slot_q, rd_nxt_q, rd_prv_q;
  logic [31:0] rd_key_q;
  lldq_pkg::rsp_t rsp_q;
  logic           rsp_valid_q;
  logic           full;
  logic [lldq_pkg::SlotW-1:0] idx_inc;

  assign full = (cnt_q >= lldq_pkg::SlotW'(lldq_pkg::Capacity));
  assign idx_inc = idx_q + 1'b1;

  // Node reads are registered; the controller passes through SRdWait after CmdRdNode/CmdRdFree.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == lldq_pkg::CmdRdNode || ctl_i.cmd == lldq_pkg::CmdRdFree) begin
      rd_key_q <= key_mem[cur_q[AW-1:0]];
      rd_nxt_q <= nxt_mem[cur_q[AW-1:0]];
      rd_prv_q <= prv_mem[cur_q[AW-1:0]];
    end
    unique case (ctl_i.cmd)
      lldq_pkg::CmdInsert: begin
        key_mem[slot_q[AW-1:0]] <= key_q;
        prv_mem[slot_q[AW-1:0]] <= lldq_pkg::NullSlot;
        nxt_mem[slot_q[AW-1:0]] <= head_q;
      end
      lldq_pkg::CmdFixHead: begin
        if (head_q != lldq_pkg::NullSlot) prv_mem[head_q[AW-1:0]] <= slot_q;
      end
      lldq_pkg::CmdUnlinkA: begin
        if (rd_prv_q != lldq_pkg::NullSlot) nxt_mem[rd_prv_q[AW-1:0]] <= rd_nxt_q;
      end
      lldq_pkg::CmdUnlinkB: begin
        if (rd_nxt_q != lldq_pkg::NullSlot) prv_mem[rd_nxt_q[AW-1:0]] <= rd_prv_q;
      end
      lldq_pkg::CmdUnlinkC: nxt_mem[cur_q[AW-1:0]] <= free_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= lldq_pkg::NullSlot;
      tail_q <= lldq_pkg::NullSlot;
      free_q <= lldq_pkg::NullSlot;
      fresh_q <= '0;
      cnt_q <= '0;
      cur_q <= '0;
      idx_q <= '0;
      slot_q <= '0;
      op_q <= '0;
      key_q <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (ctl_i.cmd)
        lldq_pkg::CmdLatch: begin
          op_q <= req_i.opcode;
          key_q <= req_i.key;
          idx_q <= '0;
          if (req_i.opcode == lldq_pkg::OpInsert && free_q != lldq_pkg::NullSlot) begin
            cur_q <= free_q;
            slot_q <= free_q;
          end else begin
            cur_q <= ctl_i.sel_tail ? tail_q : head_q;
            if (req_i.opcode == lldq_pkg::OpInsert && !full) begin
              slot_q <= fresh_q;
              fresh_q <= fresh_q + 1'b1;
            end
          end
        end
        lldq_pkg::CmdRdFree: ;
        lldq_pkg::CmdInsert: begin
          if (free_q == slot_q && free_q != lldq_pkg::NullSlot) free_q <= rd_nxt_q;
          cnt_q <= cnt_q + 1'b1;
        end
        lldq_pkg::CmdFixHead: begin
          if (head_q == lldq_pkg::NullSlot) tail_q <= slot_q;
          head_q <= slot_q;
        end
        lldq_pkg::CmdUnlinkA: begin
          if (rd_prv_q == lldq_pkg::NullSlot) head_q <= rd_nxt_q;
        end
        lldq_pkg::CmdUnlinkB: begin
          if (rd_nxt_q == lldq_pkg::NullSlot) tail_q <= rd_prv_q;
        end
        lldq_pkg::CmdUnlinkC: begin
          free_q <= cur_q;
          cnt_q <= cnt_q - 1'b1;
        end
        lldq_pkg::CmdStep: begin
          cur_q <= rd_nxt_q;
          idx_q <= idx_q + 1'b1;
        end
        lldq_pkg::CmdEmit: begin
          rsp_valid_q <= 1'b1;
          rsp_q.status <= ctl_i.status;
          rsp_q.value <= ctl_i.use_value ? rd_key_q : 32'd0;
          rsp_q.entries <= cnt_q;
          rsp_q.last_of_run <= ctl_i.last;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.opcode = op_q;
    sts_o.empty = (cnt_q == '0);
    sts_o.full = full;
    sts_o.cur_null = (cur_q == lldq_pkg::NullSlot);
    sts_o.match = (rd_key_q == key_q);
    sts_o.walk_done = (idx_inc >= cnt_q) || (rd_nxt_q == lldq_pkg::NullSlot);
  end

  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_valid_q;
  assign cnt_o = cnt_q;

endmodule

// ===== hw/rtl/lldq_ctrl.sv =====
// Controller state machine of the linked list deque.
module lldq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2:0]     opcode_i,
  input  lldq_pkg::sts_t sts_i,
  output lldq_pkg::ctl_t ctl_o,
  output logic           busy_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDecode = 3'd1;
  localparam logic [2:0] SRdWait = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SUnB = 3'd4;
  localparam logic [2:0] SUnC = 3'd5;
  localparam logic [2:0] SFix = 3'd6;
  localparam logic [2:0] SDone = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o = '{cmd: lldq_pkg::CmdNone, status: lldq_pkg::StOk, use_value: 1'b0,
              last: 1'b1, sel_tail: 1'b0};
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          ctl_o.cmd = lldq_pkg::CmdLatch;
          ctl_o.sel_tail = (opcode_i == lldq_pkg::OpDelLast);
          state_d = SDecode;
        end
      end
      SDecode: begin
        unique case (sts_i.opcode) inside
          lldq_pkg::OpInsert: begin
            if (sts_i.full) begin
              ctl_o.cmd = lldq_pkg::CmdEmit;
              ctl_o.status = lldq_pkg::StFull;
              state_d = SDone;
            end else begin
              ctl_o.cmd = lldq_pkg::CmdRdFree;
              state_d = SRdWait;
            end
          end
          lldq_pkg::OpDelKey, lldq_pkg::OpDelFirst, lldq_pkg::OpDelLast,
          lldq_pkg::OpDump: begin
            if (sts_i.empty || sts_i.cur_null) begin
              ctl_o.cmd = lldq_pkg::CmdEmit;
              ctl_o.status = lldq_pkg::StEmpty;
              state_d = SDone;
            end else begin
              ctl_o.cmd = lldq_pkg::CmdRdNode;
              state_d = SRdWait;
            end
          end
          default: begin
            ctl_o.cmd = lldq_pkg::CmdEmit;
            state_d = SDone;
          end
        endcase
      end
      SRdWait: begin
        state_d = SCheck;
      end
      SCheck: begin
        unique case (sts_i.opcode) inside
          lldq_pkg::OpInsert: begin
            ctl_o.cmd = lldq_pkg::CmdInsert;
            state_d = SFix;
          end
          lldq_pkg::OpDelFirst, lldq_pkg::OpDelLast: begin
            ctl_o.cmd = lldq_pkg::CmdUnlinkA;
            state_d = SUnB;
          end
          lldq_pkg::OpDelKey: begin
            if (sts_i.match) begin
              ctl_o.cmd = lldq_pkg::CmdUnlinkA;
              state_d = SUnB;
            end else if (sts_i.walk_done) begin
              ctl_o.cmd = lldq_pkg::CmdEmit;
              ctl_o.status = lldq_pkg::StNotFound;
              state_d = SDone;
            end else begin
              ctl_o.cmd = lldq_pkg::CmdStep;
              state_d = SDecode;
            end
          end
          default: begin
            ctl_o.cmd = lldq_pkg::CmdEmit;
            ctl_o.use_value = 1'b1;
            ctl_o.last = sts_i.walk_done;
            state_d = sts_i.walk_done ? SDone : SUnC;
          end
        endcase
      end
      SUnB: begin
        ctl_o.cmd = lldq_pkg::CmdUnlinkB;
        state_d = SUnC;
      end
      SUnC: begin
        if (sts_i.opcode == lldq_pkg::OpDump) begin
          ctl_o.cmd = lldq_pkg::CmdStep;
          state_d = SFix;
        end else begin
          ctl_o.cmd = lldq_pkg::CmdUnlinkC;
          state_d = SFix;
        end
      end
      SFix: begin
        if (sts_i.opcode == lldq_pkg::OpDump) begin
          ctl_o.cmd = lldq_pkg::CmdRdNode;
          state_d = SRdWait;
        end else begin
          if (sts_i.opcode == lldq_pkg::OpInsert) ctl_o.cmd = lldq_pkg::CmdFixHead;
          state_d = SDone;
        end
      end
      SDone: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

endmodule

// ===== hw/rtl/lldq_emit.sv =====
// Result stage: forwards datapath results and adds the final status result for insert and delete operations.
module lldq_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           done_i,
  input  logic           dp_valid_i,
  input  lldq_pkg::rsp_t dp_rsp_i,
  input  logic [6:0]     entries_i,
  output lldq_pkg::rsp_t rsp_o,
  output logic           valid_o
);

  logic pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= done_i;
    end
  end

  always_comb begin
    valid_o = dp_valid_i || pend_q;
    rsp_o = dp_rsp_i;
    if (pend_q) begin
      rsp_o = '{status: lldq_pkg::StOk, value: 32'd0, entries: entries_i, last_of_run: 1'b1};
    end
  end

endmodule
